### rtl/core/msps_pkg.sv
// shared types, constants and helper functions of the servo pulse sequencer
package msps_pkg;

  localparam int MaxChannels = 8;
  localparam int ChanW       = $clog2(MaxChannels);
  localparam int CountW      = $clog2(MaxChannels + 1);
  localparam int FrameW      = 20;
  localparam int WidthW      = 16;
  localparam int AngleW      = 8;
  localparam int ScaleW      = 33;

  localparam logic [FrameW-1:0] FrameReset = 20'd20000;
  localparam logic [FrameW-1:0] FrameTop   = 20'hFFFFF;
  localparam logic [AngleW-1:0] AngleLimit = 8'd180;
  // ceil(2^32 / 180): floor(x * AngleRecip / 2^32) == floor(x / 180) for x below 2^24
  localparam logic [ScaleW-1:0] AngleRecip = 33'd23860930;

  typedef logic [ChanW-1:0]  chan_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [WidthW-1:0] width_t;
  typedef logic [FrameW-1:0] frame_t;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_ADD  = 2'd1,
    OP_SET  = 2'd2
  } op_t;

  typedef struct packed {
    logic  found;
    chan_t idx;
  } pick_t;

  // lowest set bit of mask at or above index start
  function automatic pick_t first_from(input logic [MaxChannels-1:0] mask,
                                       input count_t start);
    pick_t p;
    p.found = 1'b0;
    p.idx   = '0;
    for (int i = MaxChannels - 1; i >= 0; i--) begin
      if (mask[i] && (CountW'(i) >= start)) begin
        p.found = 1'b1;
        p.idx   = ChanW'(i);
      end
    end
    return p;
  endfunction

  // angle times the reciprocal of 180, scaled by 2^32
  function automatic logic [ScaleW-1:0] angle_scale(input logic [AngleW-1:0] ang);
    return ScaleW'(ang) * AngleRecip;
  endfunction

endpackage

### rtl/core/multi_servo_pulse_sequencer.sv
// top level of the multichannel servo pulse sequencer
//
//  channel | direction | handshake              | contents
//  --------+-----------+------------------------+--------------------------------------
//  s_axis  | in        | tvalid / tready        | tuser op, tdata channel angle min max
//  m_axis  | out       | tvalid / tready        | tdata status pins channels_in_use
//  cfg     | in        | cfg_valid / cfg_ready  | cfg_data frame period
//
// one request per cycle unless stalled: input register, update logic, result register
// an accepted request passes through the input register and then the result register
// rst clears control state; the channel tables are not reset and are written as channels are added
// a stalled result holds the update stage, which in turn holds the input register
module multi_servo_pulse_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,   // op
  input  logic [47:0] s_axis_tdata,   // channel, angle, min_width, max_width, unused
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // status, pins, channels_in_use, zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [19:0] cfg_data
);

  localparam int N = msps_pkg::MaxChannels;

  // input register
  logic                         in_valid;
  logic [1:0]                   in_op;
  msps_pkg::chan_t              in_chan;
  logic [msps_pkg::AngleW-1:0]  in_angle;
  msps_pkg::width_t             in_min;
  msps_pkg::width_t             in_max;

  // block state
  msps_pkg::frame_t  frame_period;
  msps_pkg::count_t  channel_count;
  msps_pkg::width_t  min_tab   [N];
  msps_pkg::width_t  max_tab   [N];
  msps_pkg::width_t  width_tab [N];
  msps_pkg::frame_t  frame_timer;
  msps_pkg::width_t  pulse_timer;
  msps_pkg::chan_t   active_channel;
  logic              sequencing;

  // result register
  logic              out_valid;
  logic              out_status;
  logic [7:0]        out_pins;
  msps_pkg::count_t  out_count;

  logic fire;

  assign fire          = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || fire;
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_count, out_pins, out_status};

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op    <= s_axis_tuser;
      in_chan  <= s_axis_tdata[2:0];
      in_angle <= s_axis_tdata[10:3];
      in_min   <= s_axis_tdata[26:11];
      in_max   <= s_axis_tdata[42:27];
    end
  end

  // angle mapping for set angle
  msps_pkg::width_t set_width;

  msps_angle_map u_angle_map (
    .lo    (min_tab[in_chan]),
    .hi    (max_tab[in_chan]),
    .angle (in_angle),
    .width (set_width)
  );

  // tick and command update
  logic [N-1:0]      live;
  msps_pkg::pick_t   pick_next;
  msps_pkg::pick_t   pick_first;
  msps_pkg::width_t  pt_dec;
  logic              seq_next;
  msps_pkg::width_t  pt_next;
  msps_pkg::chan_t   ac_next;
  msps_pkg::frame_t  ft_next;
  logic              status;
  logic              add_ok;
  logic              set_ok;
  logic [16:0]       mid_sum;
  msps_pkg::chan_t   add_slot;
  msps_pkg::count_t  count_next;
  logic [7:0]        pins;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      live[i] = (width_tab[i] != '0) && (msps_pkg::CountW'(i) < channel_count);
    end
    pick_next  = msps_pkg::first_from(live, {1'b0, active_channel} + 4'd1);
    pick_first = msps_pkg::first_from(live, '0);
    pt_dec     = pulse_timer - 16'd1;
    mid_sum    = {1'b0, in_min} + {1'b0, in_max};
    add_slot   = channel_count[msps_pkg::ChanW-1:0];
    add_ok     = (channel_count < msps_pkg::CountW'(N)) && (in_min < in_max);
    set_ok     = {1'b0, in_chan} < channel_count;

    seq_next   = sequencing;
    pt_next    = pulse_timer;
    ac_next    = active_channel;
    ft_next    = frame_timer;
    count_next = channel_count;
    status     = 1'b0;

    case (in_op)
      msps_pkg::OP_TICK: begin
        if (sequencing) begin
          pt_next = pt_dec;
          if (pt_dec == '0) begin
            if (pick_next.found) begin
              ac_next = pick_next.idx;
              pt_next = width_tab[pick_next.idx];
            end else begin
              seq_next = 1'b0;
              pt_next  = '0;
            end
          end
        end
        if (frame_timer < msps_pkg::FrameTop) begin
          ft_next = frame_timer + 20'd1;
        end
        if (!seq_next && (ft_next >= frame_period)) begin
          ft_next = '0;
          if (pick_first.found) begin
            seq_next = 1'b1;
            ac_next  = pick_first.idx;
            pt_next  = width_tab[pick_first.idx];
          end else begin
            seq_next = 1'b0;
            pt_next  = '0;
          end
        end
      end
      msps_pkg::OP_ADD: begin
        status = !add_ok;
        if (add_ok) begin
          count_next = channel_count + 4'd1;
        end
      end
      msps_pkg::OP_SET: begin
        status = !set_ok;
      end
      default: begin
        status = 1'b1;
      end
    endcase

    pins = '0;
    if (seq_next) begin
      pins[ac_next] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && (in_op == msps_pkg::OP_ADD) && add_ok) begin
      min_tab[add_slot]   <= in_min;
      max_tab[add_slot]   <= in_max;
      width_tab[add_slot] <= mid_sum[16:1];
    end else if (fire && (in_op == msps_pkg::OP_SET) && set_ok) begin
      width_tab[in_chan]  <= set_width;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status <= status;
      out_pins   <= pins;
      out_count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid       <= 1'b0;
      out_valid      <= 1'b0;
      frame_period   <= msps_pkg::FrameReset;
      channel_count  <= '0;
      frame_timer    <= '0;
      pulse_timer    <= '0;
      active_channel <= '0;
      sequencing     <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        frame_period <= cfg_data;
      end
      if (fire) begin
        channel_count  <= count_next;
        frame_timer    <= ft_next;
        pulse_timer    <= pt_next;
        active_channel <= ac_next;
        sequencing     <= seq_next;
      end
    end
  end

endmodule

### rtl/core/msps_angle_map.sv
// maps a clamped angle onto a channel's pulse width range
module msps_angle_map (
  input  msps_pkg::width_t           lo,
  input  msps_pkg::width_t           hi,
  input  logic [msps_pkg::AngleW-1:0] angle,
  output msps_pkg::width_t           width
);

  localparam int ProdW = msps_pkg::WidthW + msps_pkg::ScaleW;

  logic [msps_pkg::AngleW-1:0] ang_c;
  logic [msps_pkg::ScaleW-1:0] scaled;
  msps_pkg::width_t            span;
  logic [ProdW-1:0]            prod;

  always_comb begin
    ang_c  = (angle > msps_pkg::AngleLimit) ? msps_pkg::AngleLimit : angle;
    scaled = msps_pkg::angle_scale(ang_c);
    span   = hi - lo;
    prod   = ProdW'(span) * ProdW'(scaled);
    width  = lo + prod[47:32];
  end

endmodule
